[sv/rpn_pkg.sv]
// Package for the RPN stack evaluator: character codes, status codes,
// controller states and the divider status bundle. No dependencies.
package rpn_pkg;

    localparam int DATA_W   = 32;
    localparam int CHAR_W   = 8;
    localparam int STATUS_W = 3;

    localparam logic [CHAR_W-1:0] CH_LINE_END = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_SPACE    = 8'h20;
    localparam logic [CHAR_W-1:0] CH_STAR     = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_PLUS     = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS    = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_SLASH    = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_ZERO     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE     = 8'h39;
    localparam logic [CHAR_W-1:0] CH_EQUAL    = 8'h3D;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_OVERFLOW  = 3'd1,
        ST_UNDERFLOW = 3'd2,
        ST_INVALID   = 3'd3,
        ST_DIVZERO   = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_LEFT,
        S_EXEC,
        S_DIV,
        S_EQ,
        S_EMIT
    } state_t;

    typedef enum logic [2:0] {
        K_NONE,
        K_CLEAR,
        K_LINE,
        K_PUSH,
        K_EQ,
        K_OP,
        K_FAIL
    } kind_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    function automatic logic [DATA_W-1:0] magnitude(input logic [DATA_W-1:0] x);
        return x[DATA_W-1] ? (~x + 1'b1) : x;
    endfunction

endpackage

[sv/rpn_if.sv]
// Channel interfaces for the RPN stack evaluator: character input and result output.
// Depends on rpn_pkg.
interface rpn_char_if;
    logic                           valid;
    logic                           ready;
    logic [rpn_pkg::CHAR_W-1:0]     char_code;

    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

interface rpn_result_if;
    logic                               valid;
    logic                               ready;
    logic signed [rpn_pkg::DATA_W-1:0]  value;
    logic [rpn_pkg::STATUS_W-1:0]       status;

    modport source (output valid, output value, output status, input ready);
    modport sink   (input valid, input value, input status, output ready);
endinterface

[sv/rpn_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module rpn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[sv/rpn_div.sv]
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on rpn_pkg.
module rpn_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [rpn_pkg::DATA_W-1:0]  dividend,
    input  logic [rpn_pkg::DATA_W-1:0]  divisor,
    output logic [rpn_pkg::DATA_W-1:0]  quotient,
    output rpn_pkg::div_status_t        status
);

    localparam int W    = rpn_pkg::DATA_W;
    localparam int CNTW = $clog2(W);

    logic            busy_reg;
    logic            done_reg;
    logic [CNTW-1:0] cnt_reg;
    logic [W-1:0]    rem_reg;
    logic [W-1:0]    quo_reg;
    logic [W-1:0]    den_reg;
    logic            neg_reg;

    logic [W:0]      partial;
    logic            take;
    logic [W:0]      diff;

    always_comb
    begin
        partial = {rem_reg, quo_reg[W-1]};
        take    = partial >= {1'b0, den_reg};
        diff    = partial - {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == '0);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNTW'(W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= rpn_pkg::magnitude(dividend);
            den_reg <= rpn_pkg::magnitude(divisor);
            neg_reg <= dividend[W-1] ^ divisor[W-1];
        end
        else if (busy_reg)
        begin
            rem_reg <= take ? diff[W-1:0] : partial[W-1:0];
            quo_reg <= {quo_reg[W-2:0], take};
        end
    end

    assign quotient    = neg_reg ? (~quo_reg + 1'b1) : quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

[sv/rpn_stack_evaluator.sv]
// RPN stack evaluator: takes one ASCII character per transaction and evaluates
// reverse Polish notation on an operand stack of 32-bit words held in a synchronous
// RAM of STACK_DEPTH entries. Input is ready only in the idle state: '=' goes on to
// EQ, + - * to RD_LEFT and EXEC, and '/' then waits in DIV on the bit-serial divider
// (one quotient bit per cycle). A result is loaded into the output register from
// the emit state, which waits while the result is stalled. Operands are read from
// the RAM one per cycle, right then left; errors and line ends clear the stack
// through its count, so the RAM needs no clearing after reset.
// Depends on rpn_pkg, rpn_if, rpn_ram and rpn_div.
module rpn_stack_evaluator #(
    parameter int STACK_DEPTH = 128
) (
    input  logic                clk,
    input  logic                rst_n,
    rpn_char_if.sink            in_ch,
    rpn_result_if.source        out_ch
);

    localparam int W  = rpn_pkg::DATA_W;
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    rpn_pkg::state_t              state_reg, state_next;
    logic [CW-1:0]                count_reg, count_next;
    logic                         discard_reg, discard_next;
    logic [rpn_pkg::CHAR_W-1:0]   op_reg, op_next;
    logic [W-1:0]                 right_reg, right_next;
    logic [W-1:0]                 res_value_reg, res_value_next;
    rpn_pkg::status_t             res_status_reg, res_status_next;
    logic                         out_valid_reg;
    logic [W-1:0]                 out_value_reg;
    rpn_pkg::status_t             out_status_reg;

    logic                         in_fire;
    logic                         out_load;
    rpn_pkg::kind_t               kind;
    rpn_pkg::status_t             fail_status;
    logic [AW-1:0]                top_addr;
    logic [AW-1:0]                second_addr;

    logic                         ram_we;
    logic [AW-1:0]                ram_waddr;
    logic [W-1:0]                 ram_wdata;
    logic                         ram_re;
    logic [AW-1:0]                ram_raddr;
    logic [W-1:0]                 ram_rdata;

    logic                         div_start;
    logic [W-1:0]                 div_quotient;
    rpn_pkg::div_status_t         div_st;
    logic [W-1:0]                 alu_result;

    rpn_ram #(
        .WIDTH (W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    rpn_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (ram_rdata),
        .divisor  (right_reg),
        .quotient (div_quotient),
        .status   (div_st)
    );

    assign in_ch.ready   = (state_reg == rpn_pkg::S_IDLE);
    assign in_fire       = in_ch.valid && in_ch.ready;
    assign top_addr      = AW'(count_reg - CW'(1));
    assign second_addr   = AW'(count_reg - CW'(2));
    assign out_load      = (state_reg == rpn_pkg::S_EMIT) && (!out_valid_reg || out_ch.ready);

    assign out_ch.valid  = out_valid_reg;
    assign out_ch.value  = out_value_reg;
    assign out_ch.status = out_status_reg;

    always_comb
    begin
        kind        = rpn_pkg::K_NONE;
        fail_status = rpn_pkg::ST_OK;
        if (in_ch.char_code == rpn_pkg::CH_LINE_END)
        begin
            kind = discard_reg ? rpn_pkg::K_CLEAR : rpn_pkg::K_LINE;
        end
        else if (discard_reg)
        begin
            kind = rpn_pkg::K_NONE;
        end
        else if (in_ch.char_code inside {[rpn_pkg::CH_ZERO:rpn_pkg::CH_NINE]})
        begin
            if (count_reg == CW'(STACK_DEPTH))
            begin
                kind        = rpn_pkg::K_FAIL;
                fail_status = rpn_pkg::ST_OVERFLOW;
            end
            else
            begin
                kind = rpn_pkg::K_PUSH;
            end
        end
        else if (in_ch.char_code == rpn_pkg::CH_SPACE)
        begin
            kind = rpn_pkg::K_NONE;
        end
        else if (in_ch.char_code == rpn_pkg::CH_EQUAL)
        begin
            if (count_reg == '0)
            begin
                kind        = rpn_pkg::K_FAIL;
                fail_status = rpn_pkg::ST_UNDERFLOW;
            end
            else
            begin
                kind = rpn_pkg::K_EQ;
            end
        end
        else if (in_ch.char_code inside {rpn_pkg::CH_PLUS, rpn_pkg::CH_MINUS,
                                         rpn_pkg::CH_STAR, rpn_pkg::CH_SLASH})
        begin
            if (count_reg < CW'(2))
            begin
                kind        = rpn_pkg::K_FAIL;
                fail_status = rpn_pkg::ST_UNDERFLOW;
            end
            else
            begin
                kind = rpn_pkg::K_OP;
            end
        end
        else
        begin
            kind        = rpn_pkg::K_FAIL;
            fail_status = rpn_pkg::ST_INVALID;
        end
    end

    always_comb
    begin
        case (op_reg)
            rpn_pkg::CH_PLUS:  alu_result = ram_rdata + right_reg;
            rpn_pkg::CH_MINUS: alu_result = ram_rdata - right_reg;
            rpn_pkg::CH_STAR:  alu_result = ram_rdata * right_reg;
            default:           alu_result = div_quotient;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rpn_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    case (kind)
                        rpn_pkg::K_LINE, rpn_pkg::K_FAIL: state_next = rpn_pkg::S_EMIT;
                        rpn_pkg::K_EQ:                    state_next = rpn_pkg::S_EQ;
                        rpn_pkg::K_OP:                    state_next = rpn_pkg::S_RD_LEFT;
                        default:                          state_next = rpn_pkg::S_IDLE;
                    endcase
                end
            end
            rpn_pkg::S_RD_LEFT: state_next = rpn_pkg::S_EXEC;
            rpn_pkg::S_EXEC:
            begin
                if (op_reg != rpn_pkg::CH_SLASH)
                begin
                    state_next = rpn_pkg::S_IDLE;
                end
                else if (right_reg == '0)
                begin
                    state_next = rpn_pkg::S_EMIT;
                end
                else
                begin
                    state_next = rpn_pkg::S_DIV;
                end
            end
            rpn_pkg::S_DIV:
            begin
                if (div_st.done)
                begin
                    state_next = rpn_pkg::S_IDLE;
                end
            end
            rpn_pkg::S_EQ: state_next = rpn_pkg::S_EMIT;
            rpn_pkg::S_EMIT:
            begin
                if (out_load)
                begin
                    state_next = rpn_pkg::S_IDLE;
                end
            end
            default: state_next = rpn_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        count_next      = count_reg;
        discard_next    = discard_reg;
        op_next         = op_reg;
        right_next      = right_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        ram_we          = 1'b0;
        ram_waddr       = second_addr;
        ram_wdata       = alu_result;
        ram_re          = 1'b0;
        ram_raddr       = top_addr;
        div_start       = 1'b0;
        case (state_reg)
            rpn_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    op_next = in_ch.char_code;
                    case (kind)
                        rpn_pkg::K_CLEAR:
                        begin
                            count_next   = '0;
                            discard_next = 1'b0;
                        end
                        rpn_pkg::K_LINE:
                        begin
                            count_next      = '0;
                            discard_next    = 1'b0;
                            res_value_next  = '0;
                            res_status_next = rpn_pkg::ST_OK;
                        end
                        rpn_pkg::K_PUSH:
                        begin
                            ram_we     = 1'b1;
                            ram_waddr  = count_reg[AW-1:0];
                            ram_wdata  = W'(in_ch.char_code - rpn_pkg::CH_ZERO);
                            count_next = count_reg + 1'b1;
                        end
                        rpn_pkg::K_EQ, rpn_pkg::K_OP:
                        begin
                            ram_re = 1'b1;
                        end
                        rpn_pkg::K_FAIL:
                        begin
                            count_next      = '0;
                            discard_next    = 1'b1;
                            res_value_next  = '0;
                            res_status_next = fail_status;
                        end
                        default:
                        begin
                            count_next = count_reg;
                        end
                    endcase
                end
            end
            rpn_pkg::S_RD_LEFT:
            begin
                right_next = ram_rdata;
                ram_re     = 1'b1;
                ram_raddr  = second_addr;
            end
            rpn_pkg::S_EXEC:
            begin
                if (op_reg != rpn_pkg::CH_SLASH)
                begin
                    ram_we     = 1'b1;
                    count_next = count_reg - 1'b1;
                end
                else if (right_reg == '0)
                begin
                    count_next      = '0;
                    discard_next    = 1'b1;
                    res_value_next  = '0;
                    res_status_next = rpn_pkg::ST_DIVZERO;
                end
                else
                begin
                    div_start = 1'b1;
                end
            end
            rpn_pkg::S_DIV:
            begin
                if (div_st.done)
                begin
                    ram_we     = 1'b1;
                    count_next = count_reg - 1'b1;
                end
            end
            rpn_pkg::S_EQ:
            begin
                count_next      = '0;
                discard_next    = 1'b1;
                res_value_next  = ram_rdata;
                res_status_next = rpn_pkg::ST_OK;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rpn_pkg::S_IDLE;
            count_reg     <= '0;
            discard_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            discard_reg   <= discard_next;
            out_valid_reg <= out_load || (out_valid_reg && !out_ch.ready);
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        right_reg      <= right_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        if (out_load)
        begin
            out_value_reg  <= res_value_reg;
            out_status_reg <= res_status_reg;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(STACK_DEPTH))
        else $error("operand count exceeds stack depth");

    a_discard_empty: assert property (@(posedge clk) disable iff (!rst_n)
        discard_reg |-> count_reg == '0)
        else $error("stack not empty while discarding a line");

    a_op_pops: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rpn_pkg::S_EXEC && op_reg != rpn_pkg::CH_SLASH)
        |=> count_reg == CW'($past(count_reg) - 1'b1))
        else $error("binary operator did not drop one operand");

    a_div_done_owned: assert property (@(posedge clk) disable iff (!rst_n)
        div_st.done |-> state_reg == rpn_pkg::S_DIV)
        else $error("divider finished outside the divide state");

    a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == rpn_pkg::S_EMIT)
        else $error("result raised outside the emit state");
`endif

endmodule

[test/rpn_checker.sv]
`timescale 1ns / 100ps
// Checker for the RPN stack evaluator: watches the character and result channels,
// predicts every result from the accepted characters and compares it field by field.
// Depends on rpn_pkg.
module rpn_checker #(
    parameter int STACK_DEPTH = 128
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic                               in_ready,
    input  logic [rpn_pkg::CHAR_W-1:0]         in_char,
    input  logic                               out_valid,
    input  logic                               out_ready,
    input  logic signed [rpn_pkg::DATA_W-1:0]  out_value,
    input  logic [rpn_pkg::STATUS_W-1:0]       out_status,
    output int                                 error_count,
    output int                                 pending_count
);

    typedef struct packed {
        logic signed [rpn_pkg::DATA_W-1:0] value;
        rpn_pkg::status_t                  status;
    } result_t;

    result_t                    expected_results[$];
    result_t                    oldest;
    logic [rpn_pkg::DATA_W-1:0] shadow_stack [STACK_DEPTH];
    int                         stack_fill;
    logic                       line_discard;

    task automatic queue_result(input logic [rpn_pkg::DATA_W-1:0] value,
                                input rpn_pkg::status_t status);
        result_t r;
        r.value  = value;
        r.status = status;
        expected_results.push_back(r);
    endtask

    task automatic abort_line(input rpn_pkg::status_t status);
        stack_fill   = 0;
        line_discard = 1'b1;
        queue_result('0, status);
    endtask

    task automatic evaluate_char(input logic [rpn_pkg::CHAR_W-1:0] c);
        logic [rpn_pkg::DATA_W-1:0] rhs;
        logic [rpn_pkg::DATA_W-1:0] lhs;
        logic [rpn_pkg::DATA_W-1:0] lhs_mag;
        logic [rpn_pkg::DATA_W-1:0] rhs_mag;
        logic [rpn_pkg::DATA_W-1:0] res;
        logic                       was_discarding;
        was_discarding = line_discard;
        if (c == rpn_pkg::CH_LINE_END)
        begin
            line_discard = 1'b0;
            stack_fill   = 0;
            if (!was_discarding)
                queue_result('0, rpn_pkg::ST_OK);
        end
        else if (was_discarding || c == rpn_pkg::CH_SPACE)
        begin
        end
        else if (c >= rpn_pkg::CH_ZERO && c <= rpn_pkg::CH_NINE)
        begin
            if (stack_fill >= STACK_DEPTH)
                abort_line(rpn_pkg::ST_OVERFLOW);
            else
            begin
                shadow_stack[stack_fill] = rpn_pkg::DATA_W'(c - rpn_pkg::CH_ZERO);
                stack_fill++;
            end
        end
        else if (c == rpn_pkg::CH_EQUAL)
        begin
            if (stack_fill == 0)
                abort_line(rpn_pkg::ST_UNDERFLOW);
            else
            begin
                res          = shadow_stack[stack_fill-1];
                stack_fill   = 0;
                line_discard = 1'b1;
                queue_result(res, rpn_pkg::ST_OK);
            end
        end
        else if (!(c inside {rpn_pkg::CH_PLUS, rpn_pkg::CH_MINUS,
                             rpn_pkg::CH_STAR, rpn_pkg::CH_SLASH}))
            abort_line(rpn_pkg::ST_INVALID);
        else if (stack_fill < 2)
            abort_line(rpn_pkg::ST_UNDERFLOW);
        else
        begin
            rhs = shadow_stack[stack_fill-1];
            lhs = shadow_stack[stack_fill-2];
            if (c == rpn_pkg::CH_SLASH && rhs == '0)
                abort_line(rpn_pkg::ST_DIVZERO);
            else
            begin
                case (c)
                    rpn_pkg::CH_PLUS:  res = lhs + rhs;
                    rpn_pkg::CH_MINUS: res = lhs - rhs;
                    rpn_pkg::CH_STAR:  res = lhs * rhs;
                    default:
                    begin
                        // truncate toward zero: divide magnitudes, then fix the sign
                        lhs_mag = lhs[rpn_pkg::DATA_W-1] ? -lhs : lhs;
                        rhs_mag = rhs[rpn_pkg::DATA_W-1] ? -rhs : rhs;
                        res     = lhs_mag / rhs_mag;
                        if (lhs[rpn_pkg::DATA_W-1] ^ rhs[rpn_pkg::DATA_W-1])
                            res = -res;
                    end
                endcase
                stack_fill--;
                shadow_stack[stack_fill-1] = res;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stack_fill    = 0;
            line_discard  = 1'b0;
            expected_results.delete();
            error_count   = 0;
            pending_count = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result: value %0d, status %0d",
                           out_value, out_status);
                    error_count++;
                end
                else
                begin
                    oldest = expected_results.pop_front();
                    if (out_value !== oldest.value)
                    begin
                        $error("value: expected %0d, actual %0d", oldest.value, out_value);
                        error_count++;
                    end
                    if (out_status !== oldest.status)
                    begin
                        $error("status: expected %0d, actual %0d", oldest.status, out_status);
                        error_count++;
                    end
                end
            end
            if (in_valid && in_ready)
                evaluate_char(in_char);
            pending_count = expected_results.size();
        end
    end

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps
// Top of the RPN stack evaluator test: drives character lines with random idling and
// result stalls, and gives the verdict from the checker's mismatch and pending counts.
// Depends on rpn_pkg, rpn_if, rpn_stack_evaluator and rpn_checker.
module testbench;

    localparam int STACK_DEPTH    = 128;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 64;
    localparam int PHASE_ITEMS    = 400;
    localparam logic [rpn_pkg::CHAR_W-1:0] CH_RETURN = 8'h0D;

    logic clk = 1'b0;
    logic rst_n;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   items_sent;
    int   idle_cycles;
    int   error_count;
    int   pending_count;
    logic [rpn_pkg::CHAR_W-1:0] line_buf[$];

    rpn_char_if   char_bus ();
    rpn_result_if result_bus ();

    rpn_stack_evaluator #(
        .STACK_DEPTH (STACK_DEPTH)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (char_bus),
        .out_ch (result_bus)
    );

    rpn_checker #(
        .STACK_DEPTH (STACK_DEPTH)
    ) i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (char_bus.valid),
        .in_ready      (char_bus.ready),
        .in_char       (char_bus.char_code),
        .out_valid     (result_bus.valid),
        .out_ready     (result_bus.ready),
        .out_value     (result_bus.value),
        .out_status    (result_bus.status),
        .error_count   (error_count),
        .pending_count (pending_count)
    );

    always #2 clk = ~clk;

    always @(negedge clk)
        result_bus.ready <= ($urandom_range(99) >= recv_stall_pct);

    // abort when no transaction moves for too long
    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((char_bus.valid && char_bus.ready) || (result_bus.valid && result_bus.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("** rpn_stack_evaluator: FAILED **");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    function automatic logic [rpn_pkg::CHAR_W-1:0] random_digit(input int lo, input int hi);
        return rpn_pkg::CH_ZERO + rpn_pkg::CHAR_W'($urandom_range(hi, lo));
    endfunction

    function automatic logic [rpn_pkg::CHAR_W-1:0] random_op();
        case ($urandom_range(3))
            0:       return rpn_pkg::CH_PLUS;
            1:       return rpn_pkg::CH_MINUS;
            2:       return rpn_pkg::CH_STAR;
            default: return rpn_pkg::CH_SLASH;
        endcase
    endfunction

    function automatic logic [rpn_pkg::CHAR_W-1:0] noise_char();
        int roll;
        roll = $urandom_range(9);
        if (roll < 4)
            return random_digit(0, 9);
        else if (roll < 6)
            return random_op();
        else if (roll == 6)
            return rpn_pkg::CH_EQUAL;
        else if (roll == 7)
            return rpn_pkg::CH_SPACE;
        return rpn_pkg::CHAR_W'($urandom_range(255));
    endfunction

    // Entered just after a rising edge; returns at the edge that accepts c.
    task automatic send_char(input logic [rpn_pkg::CHAR_W-1:0] c);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            char_bus.valid <= 1'b0;
            @(negedge clk);
        end
        char_bus.valid     <= 1'b1;
        char_bus.char_code <= c;
        do
            @(posedge clk);
        while (char_bus.ready !== 1'b1);
        items_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
    endtask

    task automatic send_line();
        foreach (line_buf[i])
            send_char(line_buf[i]);
        line_buf.delete();
    endtask

    task automatic build_expression(input bit corrupt);
        int depth;
        int pushes;
        int max_pushes;
        depth      = 0;
        pushes     = 0;
        max_pushes = $urandom_range(8, 1);
        while (pushes < max_pushes || depth > 1)
        begin
            if (depth >= 2 && (pushes >= max_pushes || $urandom_range(1) == 1))
            begin
                line_buf.push_back(random_op());
                depth--;
            end
            else
            begin
                line_buf.push_back(random_digit(0, 9));
                depth++;
                pushes++;
            end
            if ($urandom_range(99) < 15)
                line_buf.push_back(rpn_pkg::CH_SPACE);
        end
        if ($urandom_range(99) < 85)
        begin
            line_buf.push_back(rpn_pkg::CH_EQUAL);
            if ($urandom_range(3) == 0)
                repeat ($urandom_range(3, 1)) line_buf.push_back(noise_char());
        end
        if (corrupt)
            line_buf.insert($urandom_range(line_buf.size()),
                            rpn_pkg::CHAR_W'($urandom_range(255)));
        line_buf.push_back(rpn_pkg::CH_LINE_END);
    endtask

    task automatic build_noise();
        repeat ($urandom_range(6, 1)) line_buf.push_back(noise_char());
        line_buf.push_back(rpn_pkg::CH_LINE_END);
    endtask

    // Long products that wrap; exact_min builds 8^10 * 2, the most negative word.
    task automatic build_wrap(input bit exact_min);
        if (exact_min)
        begin
            line_buf.push_back(rpn_pkg::CH_ZERO + 8'd8);
            repeat (9)
            begin
                line_buf.push_back(rpn_pkg::CH_ZERO + 8'd8);
                line_buf.push_back(rpn_pkg::CH_STAR);
            end
            line_buf.push_back(rpn_pkg::CH_ZERO + 8'd2);
            line_buf.push_back(rpn_pkg::CH_STAR);
        end
        else
        begin
            line_buf.push_back(random_digit(2, 9));
            repeat ($urandom_range(16, 10))
            begin
                line_buf.push_back(random_digit(2, 9));
                line_buf.push_back(rpn_pkg::CH_STAR);
            end
        end
        if (exact_min || $urandom_range(1) == 1)
        begin
            line_buf.push_back(rpn_pkg::CH_ZERO);
            line_buf.push_back(rpn_pkg::CH_ZERO + 8'd1);
            line_buf.push_back(rpn_pkg::CH_MINUS);
            line_buf.push_back(exact_min && $urandom_range(1) == 1 ? rpn_pkg::CH_SLASH
                                                                   : random_op());
        end
        line_buf.push_back(rpn_pkg::CH_EQUAL);
        line_buf.push_back(rpn_pkg::CH_LINE_END);
    endtask

    // Fill the stack to around its depth; overflow when it goes past.
    task automatic build_deep();
        int pushes;
        pushes = $urandom_range(STACK_DEPTH + 2, STACK_DEPTH - 2);
        repeat (pushes) line_buf.push_back(random_digit(1, 9));
        repeat ((pushes > STACK_DEPTH ? STACK_DEPTH : pushes) - 1)
        begin
            case ($urandom_range(2))
                0:       line_buf.push_back(rpn_pkg::CH_PLUS);
                1:       line_buf.push_back(rpn_pkg::CH_MINUS);
                default: line_buf.push_back(rpn_pkg::CH_STAR);
            endcase
        end
        line_buf.push_back(rpn_pkg::CH_EQUAL);
        line_buf.push_back(rpn_pkg::CH_LINE_END);
    endtask

    task automatic build_random_line();
        int roll;
        roll = $urandom_range(99);
        if (roll < 62)
            build_expression(1'b0);
        else if (roll < 74)
            build_expression(1'b1);
        else if (roll < 88)
            build_noise();
        else if (roll < 99)
            build_wrap(roll < 93);
        else
            build_deep();
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct);
        int target;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        target         = items_sent + PHASE_ITEMS;
        while (items_sent < target)
        begin
            build_random_line();
            send_line();
        end
    endtask

    initial
    begin
        char_bus.valid     = 1'b0;
        char_bus.char_code = '0;
        rst_n              = 1'b0;
        send_idle_pct      = 0;
        recv_stall_pct     = 0;
        items_sent         = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_text("\n");
        send_text("=\n");
        send_text("5+\n");
        send_char(CH_RETURN);
        send_text("\n");
        send_char(8'hFF);
        send_text("\n");
        send_text("90/\n");
        send_text("93/=7\n");
        send_text("98*7+3-=\n");

        build_deep();
        send_line();
        run_phase(0, 0);
        run_phase(58, 0);
        run_phase(0, 58);
        run_phase(19, 19);

        @(negedge clk);
        char_bus.valid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (error_count == 0 && pending_count == 0)
            $display("** rpn_stack_evaluator: PASSED **");
        else
            $display("** rpn_stack_evaluator: FAILED **");
        $finish;
    end

endmodule

[rpn_stack_evaluator.f]
sv/rpn_pkg.sv
sv/rpn_if.sv
sv/rpn_ram.sv
sv/rpn_div.sv
sv/rpn_stack_evaluator.sv
test/rpn_checker.sv
test/testbench.sv
